>>> src/tct_pkg.sv
package tct_pkg;

    // Table geometry
    localparam int NUM_FLOWS = 64;
    localparam int IDX_W     = $clog2(NUM_FLOWS);
    localparam int MAX_REC   = 64;
    localparam int CNT_W     = $clog2(MAX_REC + 1);
    localparam int QDEPTH    = 2;
    localparam int WORD_BYTES = 4;

    localparam logic [15:0] TIMEOUT_RESET = 16'd60;
    localparam logic [31:0] PKT_MAX  = 32'hFFFF_FFFF;
    localparam logic [47:0] BYTE_MAX = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        PH_PENDING     = 2'd0,
        PH_EST         = 2'd1,
        PH_CLIENT_HALF = 2'd2,
        PH_SERVER_HALF = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        KIND_NONE     = 3'd0,
        KIND_CLOSED   = 3'd1,
        KIND_RESET    = 3'd2,
        KIND_TIMEOUT  = 3'd3,
        KIND_REPLACED = 3'd4,
        KIND_FULL     = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        CMD_NONE   = 3'd0,
        CMD_SWEEP  = 3'd1,
        CMD_RST    = 3'd2,
        CMD_SYN    = 3'd3,
        CMD_SYNACK = 3'd4,
        CMD_FIN    = 3'd5,
        CMD_DATA   = 3'd6
    } t_cmd_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_READ,
        ST_EXEC,
        ST_SW_RD,
        ST_SW_CHK,
        ST_SW_END
    } t_state;

    // Classified item handed from the front to the back
    typedef struct packed {
        t_cmd_kind   kind;
        logic [31:0] now;
        logic [31:0] sa;
        logic [31:0] da;
        logic [15:0] sp;
        logic [15:0] dp;
        logic [15:0] bytes;
    } t_cmd;

    typedef struct packed {
        logic [31:0] cip;
        logic [15:0] cport;
        logic [31:0] sip;
        logic [15:0] sport;
    } t_key;

    // One table entry as kept in the data memory
    typedef struct packed {
        t_phase      phase;
        logic [47:0] sb;
        logic [47:0] qb;
        logic [31:0] sp;
        logic [31:0] qp;
        logic [31:0] t1;
        logic [31:0] t0;
        logic [15:0] sport;
        logic [15:0] cport;
        logic [31:0] sip;
        logic [31:0] cip;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic        last;
        t_kind       kind;
        logic [47:0] sb;
        logic [47:0] qb;
        logic [31:0] sp;
        logic [31:0] qp;
        logic [31:0] t1;
        logic [31:0] t0;
        logic [15:0] sport;
        logic [15:0] cport;
        logic [31:0] sip;
        logic [31:0] cip;
    } t_rec;

endpackage

>>> src/tct_ram.sv
module tct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/tct_front.sv
module tct_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [175:0]      i_s_tdata,
    input  logic              i_s_tuser,
    output logic              o_q_valid,
    output tct_pkg::t_cmd     o_q_cmd,
    input  logic              i_q_pop
);

    tct_pkg::t_cmd     r_q [tct_pkg::QDEPTH];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;
    tct_pkg::t_cmd     cmd;
    logic [7:0]        flags;
    logic [3:0]        hw;
    logic [15:0]       seg;
    logic              fin, syn, rst, ack, ece, cwr;
    logic              push;

    assign flags = i_s_tdata[135:128];
    assign hw    = i_s_tdata[139:136];
    assign seg   = i_s_tdata[155:140];
    assign fin   = flags[0];
    assign syn   = flags[1];
    assign rst   = flags[2];
    assign ack   = flags[4];
    assign ece   = flags[6];
    assign cwr   = flags[7];

    // Classify the beat by opcode and flag byte, first matching rule wins.
    always_comb begin
        cmd.now   = i_s_tdata[31:0];
        cmd.sa    = i_s_tdata[63:32];
        cmd.da    = i_s_tdata[95:64];
        cmd.sp    = i_s_tdata[111:96];
        cmd.dp    = i_s_tdata[127:112];
        cmd.bytes = i_s_tdata[171:156];
        priority if (i_s_tuser) begin
            cmd.kind = tct_pkg::CMD_SWEEP;
        end else if (rst && ack) begin
            cmd.kind = tct_pkg::CMD_RST;
        end else if (syn && !ack && !ece && !cwr) begin
            cmd.kind = tct_pkg::CMD_SYN;
        end else if (syn && ack) begin
            cmd.kind = tct_pkg::CMD_SYNACK;
        end else if (fin && ack) begin
            cmd.kind = tct_pkg::CMD_FIN;
        end else if (seg > {10'd0, hw, 2'b00}) begin
            cmd.kind = tct_pkg::CMD_DATA;
        end else begin
            cmd.kind = tct_pkg::CMD_NONE;
        end
    end

    assign o_s_tready = (r_cnt != 2'(tct_pkg::QDEPTH));
    assign push       = i_s_tvalid && o_s_tready && (cmd.kind != tct_pkg::CMD_NONE);
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_cmd    = r_q[r_rp];

    // Short queue of classified items; items with no effect are dropped here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_q[r_wp] <= cmd;
                r_wp      <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

endmodule

>>> src/tct_back.sv
module tct_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [15:0]       i_timeout,
    input  logic              i_q_valid,
    input  tct_pkg::t_cmd     i_q_cmd,
    output logic              o_q_pop,
    output logic              o_out_valid,
    output tct_pkg::t_rec     o_out,
    input  logic              i_out_ready
);

    localparam int N = tct_pkg::NUM_FLOWS;
    localparam int IW = tct_pkg::IDX_W;

    tct_pkg::t_state   r_state, n_state;
    tct_pkg::t_cmd     r_cmd, n_cmd;
    logic [IW-1:0]     r_idx, n_idx;
    logic              r_hit, n_hit;
    logic              r_fwd, n_fwd;
    logic              r_free, n_free;
    logic [N-1:0]      r_valid, n_valid;
    tct_pkg::t_phase   r_phase [N];
    tct_pkg::t_phase   n_phase [N];
    tct_pkg::t_key     r_key [N];
    tct_pkg::t_key     n_key [N];
    logic              r_out_valid, n_out_valid;
    tct_pkg::t_rec     r_out, n_out;
    logic              r_pend_valid, n_pend_valid;
    tct_pkg::t_rec     r_pend, n_pend;
    logic [tct_pkg::CNT_W-1:0] r_cnt, n_cnt;

    logic                  ram_we;
    tct_pkg::t_entry       ram_wdata;
    tct_pkg::t_entry       e;
    logic [tct_pkg::ENTRY_W-1:0] ram_rdata;
    logic [N-1:0]          fm, rm;
    logic [3:0]            fmask, rmask;
    tct_pkg::t_key         fkey, rkey;
    tct_pkg::t_entry       ne;
    tct_pkg::t_entry       fresh;
    logic                  out_free;
    logic                  expired;
    logic                  closing;
    logic [31:0]           age;

    function automatic logic [IW-1:0] lowest(input logic [N-1:0] v);
        logic [IW-1:0] idx;
        idx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = IW'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [31:0] sat_pkt(input logic [31:0] a);
        return (a == tct_pkg::PKT_MAX) ? a : a + 32'd1;
    endfunction

    function automatic logic [47:0] sat_bytes(input logic [47:0] a, input logic [15:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {33'd0, b};
        return s[48] ? tct_pkg::BYTE_MAX : s[47:0];
    endfunction

    function automatic tct_pkg::t_rec mk_rec(input tct_pkg::t_kind k,
                                              input tct_pkg::t_entry f);
        tct_pkg::t_rec r;
        r.last  = 1'b1;
        r.kind  = k;
        r.sb    = f.sb;
        r.qb    = f.qb;
        r.sp    = f.sp;
        r.qp    = f.qp;
        r.t1    = f.t1;
        r.t0    = f.t0;
        r.sport = f.sport;
        r.cport = f.cport;
        r.sip   = f.sip;
        r.cip   = f.cip;
        return r;
    endfunction

    // Entry data memory: tuple copy, phase copy, times and counters.
    tct_ram #(
        .WIDTH(tct_pkg::ENTRY_W),
        .DEPTH(N)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign e = tct_pkg::t_entry'(ram_rdata);

    // Forward and reversed tuples of the current packet.
    assign fkey = '{cip: r_cmd.sa, cport: r_cmd.sp, sip: r_cmd.da, sport: r_cmd.dp};
    assign rkey = '{cip: r_cmd.da, cport: r_cmd.dp, sip: r_cmd.sa, sport: r_cmd.sp};

    // Phase masks per command: bit p set lets phase p match.
    always_comb begin
        unique case (r_cmd.kind)
            tct_pkg::CMD_RST: begin
                fmask = 4'b0000;
                rmask = 4'b1111;
            end
            tct_pkg::CMD_SYN: begin
                fmask = 4'b1111;
                rmask = 4'b0000;
            end
            tct_pkg::CMD_SYNACK: begin
                fmask = 4'b0000;
                rmask = 4'b0001;
            end
            tct_pkg::CMD_FIN: begin
                fmask = 4'b1110;
                rmask = 4'b1110;
            end
            tct_pkg::CMD_DATA: begin
                fmask = 4'b0010;
                rmask = 4'b0010;
            end
            default: begin
                fmask = 4'b0000;
                rmask = 4'b0000;
            end
        endcase
    end

    // Parallel key compare against every entry.
    always_comb begin
        for (int i = 0; i < N; i++) begin
            fm[i] = r_valid[i] && (r_key[i] == fkey) && fmask[r_phase[i]];
            rm[i] = r_valid[i] && (r_key[i] == rkey) && rmask[r_phase[i]];
        end
    end

    assign out_free = !r_out_valid || i_out_ready;
    assign age      = r_cmd.now - e.t0;
    assign expired  = (e.phase != tct_pkg::PH_EST) && (age >= {16'd0, i_timeout});

    // A freshly opened session for a plain SYN.
    always_comb begin
        fresh.phase = tct_pkg::PH_PENDING;
        fresh.cip   = r_cmd.sa;
        fresh.cport = r_cmd.sp;
        fresh.sip   = r_cmd.da;
        fresh.sport = r_cmd.dp;
        fresh.t0    = r_cmd.now;
        fresh.t1    = 32'd0;
        fresh.qp    = 32'd1;
        fresh.sp    = 32'd0;
        fresh.qb    = {32'd0, r_cmd.bytes};
        fresh.sb    = 48'd0;
    end

    // Sequencer for next state, table updates and records.
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_idx        = r_idx;
        n_hit        = r_hit;
        n_fwd        = r_fwd;
        n_free       = r_free;
        n_valid      = r_valid;
        n_phase      = r_phase;
        n_key        = r_key;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_cnt        = r_cnt;
        o_q_pop      = 1'b0;
        ram_we       = 1'b0;
        ne           = e;
        closing      = 1'b0;

        unique case (r_state)
            tct_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_idx   = '0;
                    n_cnt   = '0;
                    n_state = (i_q_cmd.kind == tct_pkg::CMD_SWEEP) ?
                              tct_pkg::ST_SW_RD : tct_pkg::ST_MATCH;
                end
            end

            tct_pkg::ST_MATCH: begin
                n_free = 1'b0;
                priority if (|fm) begin
                    n_idx = lowest(fm);
                    n_hit = 1'b1;
                    n_fwd = 1'b1;
                end else if (|rm) begin
                    n_idx = lowest(rm);
                    n_hit = 1'b1;
                    n_fwd = 1'b0;
                end else begin
                    n_hit = 1'b0;
                    n_fwd = 1'b0;
                    if ((r_cmd.kind == tct_pkg::CMD_SYN) && !(&r_valid)) begin
                        n_idx  = lowest(~r_valid);
                        n_free = 1'b1;
                    end
                end
                n_state = tct_pkg::ST_READ;
            end

            tct_pkg::ST_READ: begin
                n_state = tct_pkg::ST_EXEC;
            end

            tct_pkg::ST_EXEC: begin
                if (out_free) begin
                    n_state = tct_pkg::ST_IDLE;
                    unique case (r_cmd.kind)
                        tct_pkg::CMD_RST: begin
                            if (r_hit) begin
                                ne.t1 = r_cmd.now;
                                ne.sp = sat_pkt(e.sp);
                                ne.sb = sat_bytes(e.sb, r_cmd.bytes);
                                n_out_valid    = 1'b1;
                                n_out          = mk_rec(tct_pkg::KIND_RESET, ne);
                                n_valid[r_idx] = 1'b0;
                            end
                        end
                        tct_pkg::CMD_SYN: begin
                            ne = fresh;
                            if (r_hit || r_free) begin
                                if (r_hit) begin
                                    n_out_valid = 1'b1;
                                    n_out       = mk_rec(tct_pkg::KIND_REPLACED, e);
                                end
                                ram_we         = 1'b1;
                                n_valid[r_idx] = 1'b1;
                                n_key[r_idx]   = fkey;
                                n_phase[r_idx] = tct_pkg::PH_PENDING;
                            end else begin
                                ne.qp       = 32'd0;
                                ne.qb       = 48'd0;
                                n_out_valid = 1'b1;
                                n_out       = mk_rec(tct_pkg::KIND_FULL, ne);
                            end
                        end
                        tct_pkg::CMD_SYNACK: begin
                            if (r_hit) begin
                                ne.sp          = 32'd1;
                                ne.sb          = {32'd0, r_cmd.bytes};
                                ne.phase       = tct_pkg::PH_EST;
                                ram_we         = 1'b1;
                                n_phase[r_idx] = tct_pkg::PH_EST;
                            end
                        end
                        tct_pkg::CMD_FIN: begin
                            if (r_hit) begin
                                ne.t1 = r_cmd.now;
                                if (r_fwd) begin
                                    ne.qp    = sat_pkt(e.qp);
                                    ne.qb    = sat_bytes(e.qb, r_cmd.bytes);
                                    closing  = (e.phase == tct_pkg::PH_SERVER_HALF);
                                    ne.phase = tct_pkg::PH_CLIENT_HALF;
                                end else begin
                                    ne.sp    = sat_pkt(e.sp);
                                    ne.sb    = sat_bytes(e.sb, r_cmd.bytes);
                                    closing  = (e.phase == tct_pkg::PH_CLIENT_HALF);
                                    ne.phase = tct_pkg::PH_SERVER_HALF;
                                end
                                if (closing) begin
                                    n_out_valid    = 1'b1;
                                    n_out          = mk_rec(tct_pkg::KIND_CLOSED, ne);
                                    n_valid[r_idx] = 1'b0;
                                end else begin
                                    ram_we         = 1'b1;
                                    n_phase[r_idx] = ne.phase;
                                end
                            end
                        end
                        tct_pkg::CMD_DATA: begin
                            if (r_hit) begin
                                if (r_fwd) begin
                                    ne.qp = sat_pkt(e.qp);
                                    ne.qb = sat_bytes(e.qb, r_cmd.bytes);
                                end else begin
                                    ne.sp = sat_pkt(e.sp);
                                    ne.sb = sat_bytes(e.sb, r_cmd.bytes);
                                end
                                ram_we = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Sweep: visit entries in index order, read each valid one.
            tct_pkg::ST_SW_RD: begin
                if (r_valid[r_idx]) begin
                    n_state = tct_pkg::ST_SW_CHK;
                end else if (r_idx == IW'(N - 1)) begin
                    n_state = tct_pkg::ST_SW_END;
                end else begin
                    n_idx   = r_idx + 1'b1;
                end
            end

            // Expired entries go to a holding record so that the final one
            // can be marked last once the walk is over.
            tct_pkg::ST_SW_CHK: begin
                if (!expired) begin
                    if (r_idx == IW'(N - 1)) begin
                        n_state = tct_pkg::ST_SW_END;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = tct_pkg::ST_SW_RD;
                    end
                end else if (!r_pend_valid || out_free) begin
                    if (r_pend_valid) begin
                        n_out_valid = 1'b1;
                        n_out       = r_pend;
                        n_out.last  = 1'b0;
                    end
                    n_pend_valid   = 1'b1;
                    n_pend         = mk_rec(tct_pkg::KIND_TIMEOUT, e);
                    n_valid[r_idx] = 1'b0;
                    n_cnt          = r_cnt + 1'b1;
                    if ((n_cnt == tct_pkg::CNT_W'(tct_pkg::MAX_REC)) ||
                        (r_idx == IW'(N - 1))) begin
                        n_state = tct_pkg::ST_SW_END;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = tct_pkg::ST_SW_RD;
                    end
                end
            end

            tct_pkg::ST_SW_END: begin
                if (!r_pend_valid) begin
                    n_state = tct_pkg::ST_IDLE;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out        = r_pend;
                    n_out.last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = tct_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = tct_pkg::ST_IDLE;
            end
        endcase
        ram_wdata = ne;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tct_pkg::ST_IDLE;
            r_valid      <= '0;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_valid      <= n_valid;
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
        end
    end

    // Payload and per-entry match fields.
    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_idx   <= n_idx;
        r_hit   <= n_hit;
        r_fwd   <= n_fwd;
        r_free  <= n_free;
        r_phase <= n_phase;
        r_key   <= n_key;
        r_out   <= n_out;
        r_pend  <= n_pend;
        r_cnt   <= n_cnt;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> src/tcp_connection_tracker_unit.sv
// TCP session tracker over a flow table of tct_pkg::NUM_FLOWS entries. Input
// beats are classified as they arrive and wait in a two-entry queue; a packet
// then goes through the steps of the execution sequencer (dequeue, parallel tuple
// match, entry memory read, update and record), with the entry memory read
// registered ahead of the update; the next packet waits for it to finish.
// A sweep walks every table index in order, reading and checking each valid
// entry, and emits a timed-out record for each expired pending or half-closed
// session (at most 64 per sweep), the final one with tlast high.
// Input beats are taken while earlier work proceeds until the queue fills. A
// finished record waits in the output register while the next item is matched
// and read, and the update step of that item waits until the record has left.
// The timeout register may be written only while the block is idle.
module tcp_connection_tracker_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // Timeout register write
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [15:0]   i_cfg_data,
    // Input items
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // now, src_ip, dst_ip, src_port, dst_port, tcp_flags, header_words,
    // segment_len, frame_len, zero fill to 176 bits
    input  logic [175:0]  i_s_tdata,
    // opcode
    input  logic          i_s_tuser,
    // Result records
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // client_ip, server_ip, client_port, server_port, start_time, end_time,
    // req_pkts, rsp_pkts, req_bytes, rsp_bytes
    output logic [319:0]  o_m_tdata,
    // record_kind
    output logic [2:0]    o_m_tuser,
    output logic          o_m_tlast
);

    logic [15:0]       r_timeout_val;
    logic              q_valid;
    tct_pkg::t_cmd     q_cmd;
    logic              q_pop;
    tct_pkg::t_rec     rec;

    assign o_cfg_ready = 1'b1;

    // Timeout register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_val <= tct_pkg::TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            r_timeout_val <= i_cfg_data;
        end
    end

    tct_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_q_valid  (q_valid),
        .o_q_cmd    (q_cmd),
        .i_q_pop    (q_pop)
    );

    tct_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_timeout   (r_timeout_val),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_m_tvalid),
        .o_out       (rec),
        .i_out_ready (i_m_tready)
    );

    // Record fields onto the output beat.
    assign o_m_tdata = {rec.sb, rec.qb, rec.sp, rec.qp, rec.t1, rec.t0,
                        rec.sport, rec.cport, rec.sip, rec.cip};
    assign o_m_tuser = rec.kind;
    assign o_m_tlast = rec.last;

endmodule
